FILE: rtl/core/jloc_pkg.sv
`timescale 1ns / 1ps

package jloc_pkg;

  // Lepton store depth and the widths that follow from it
  localparam int MaxLeptons = 16;
  localparam int LepIdxW    = (MaxLeptons > 1) ? $clog2(MaxLeptons) : 1;
  localparam int LepCntW    = $clog2(MaxLeptons + 1);

  // Field widths
  localparam int PtW    = 16;
  localparam int EtaW   = 13;
  localparam int PhiW   = 12;
  localparam int AbsEtaW = 12;
  localparam int DrSqW  = 24;
  localparam int CutW   = 4;

  // Distance arithmetic widths
  localparam int DEtaAbsW = EtaW;            // |deta| <= 8191
  localparam int DPhiAbsW = PhiW;            // |dphi| <= 2048
  localparam int DEtaSqW  = 2 * DEtaAbsW;
  localparam int DPhiSqW  = 2 * DPhiAbsW;
  localparam int DistSqW  = DEtaSqW + 1;

  // APB register map
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Register reset values
  localparam logic [AbsEtaW-1:0] MinAbsEtaRst = 12'd0;
  localparam logic [AbsEtaW-1:0] MaxAbsEtaRst = 12'd3260;
  localparam logic [PtW-1:0]     MinPtRst     = 16'd80;
  localparam logic [PtW-1:0]     MaxPtRst     = 16'd65535;
  localparam logic [CutW-1:0]    CutEnRst     = 4'hF;
  localparam logic [DrSqW-1:0]   DrSqRst      = 24'd106276;

  // cut_enable bit positions
  localparam int CutMinEta = 0;
  localparam int CutMaxEta = 1;
  localparam int CutMinPt  = 2;
  localparam int CutMaxPt  = 3;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD_MU  = 2'd1,
    OP_ADD_EL  = 2'd2,
    OP_TEST_JET = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MIN_ABS_ETA = 3'd0,
    REG_MAX_ABS_ETA = 3'd1,
    REG_MIN_PT      = 3'd2,
    REG_MAX_PT      = 3'd3,
    REG_CUT_ENABLE  = 3'd4,
    REG_MU_DR_SQ    = 3'd5,
    REG_EL_DR_SQ    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [EtaW-1:0] eta;
    logic signed [PhiW-1:0] phi;
  } lep_entry_t;

endpackage

FILE: rtl/core/jet_lepton_overlap_clean_unit.sv
`timescale 1ns / 1ps

// Jet acceptance and jet to lepton overlap removal. Muons and electrons
// (eta, phi) of the current event are kept in two 16-entry synchronous RAMs;
// a clear item empties both and drops the overflow flag. A clear or add item
// is taken while idle and makes no result. A test-jet item reads the stored
// entries one per cycle through a shared three-stage distance pipe (RAM read,
// squares, add and compare against the squared threshold), muons first, then
// electrons. The input stalls while a jet is being scanned; a finished result
// sits in the output register while the next item is taken.
// Eta and phi are in units of pi/2048, phi differences wrap modulo 4096, pt in
// units of 0.25 GeV. Leptons past the store depth are dropped and flagged.
module jet_lepton_overlap_clean_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic [jloc_pkg::PtW-1:0]          in_obj_pt,
  input  logic signed [jloc_pkg::EtaW-1:0]  in_obj_eta,
  input  logic signed [jloc_pkg::PhiW-1:0]  in_obj_phi,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_jet_pass,
  output logic                              out_jet_in_acceptance,
  output logic                              out_jet_clean,
  output logic                              out_lepton_overflow,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [jloc_pkg::AddrW-1:0]        paddr,
  input  logic [jloc_pkg::DataW-1:0]        pwdata,
  output logic [jloc_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [jloc_pkg::AbsEtaW-1:0] min_abs_eta_r;
  logic [jloc_pkg::AbsEtaW-1:0] max_abs_eta_r;
  logic [jloc_pkg::PtW-1:0]     min_pt_r;
  logic [jloc_pkg::PtW-1:0]     max_pt_r;
  logic [jloc_pkg::CutW-1:0]    cut_en_r;
  logic [jloc_pkg::DrSqW-1:0]   mu_thr_r;
  logic [jloc_pkg::DrSqW-1:0]   el_thr_r;

  logic               cfg_wr;
  jloc_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = jloc_pkg::reg_idx_t'(paddr[jloc_pkg::AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_abs_eta_r <= jloc_pkg::MinAbsEtaRst;
      max_abs_eta_r <= jloc_pkg::MaxAbsEtaRst;
      min_pt_r      <= jloc_pkg::MinPtRst;
      max_pt_r      <= jloc_pkg::MaxPtRst;
      cut_en_r      <= jloc_pkg::CutEnRst;
      mu_thr_r      <= jloc_pkg::DrSqRst;
      el_thr_r      <= jloc_pkg::DrSqRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        jloc_pkg::REG_MIN_ABS_ETA: min_abs_eta_r <= pwdata[jloc_pkg::AbsEtaW-1:0];
        jloc_pkg::REG_MAX_ABS_ETA: max_abs_eta_r <= pwdata[jloc_pkg::AbsEtaW-1:0];
        jloc_pkg::REG_MIN_PT:      min_pt_r      <= pwdata[jloc_pkg::PtW-1:0];
        jloc_pkg::REG_MAX_PT:      max_pt_r      <= pwdata[jloc_pkg::PtW-1:0];
        jloc_pkg::REG_CUT_ENABLE:  cut_en_r      <= pwdata[jloc_pkg::CutW-1:0];
        jloc_pkg::REG_MU_DR_SQ:    mu_thr_r      <= pwdata[jloc_pkg::DrSqW-1:0];
        jloc_pkg::REG_EL_DR_SQ:    el_thr_r      <= pwdata[jloc_pkg::DrSqW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      jloc_pkg::REG_MIN_ABS_ETA: prdata = jloc_pkg::DataW'(min_abs_eta_r);
      jloc_pkg::REG_MAX_ABS_ETA: prdata = jloc_pkg::DataW'(max_abs_eta_r);
      jloc_pkg::REG_MIN_PT:      prdata = jloc_pkg::DataW'(min_pt_r);
      jloc_pkg::REG_MAX_PT:      prdata = jloc_pkg::DataW'(max_pt_r);
      jloc_pkg::REG_CUT_ENABLE:  prdata = jloc_pkg::DataW'(cut_en_r);
      jloc_pkg::REG_MU_DR_SQ:    prdata = jloc_pkg::DataW'(mu_thr_r);
      jloc_pkg::REG_EL_DR_SQ:    prdata = jloc_pkg::DataW'(el_thr_r);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  jloc_pkg::state_t state_r, state_nxt;

  logic [jloc_pkg::LepCntW-1:0] mu_cnt_r, mu_cnt_nxt;
  logic [jloc_pkg::LepCntW-1:0] el_cnt_r, el_cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [jloc_pkg::LepCntW-1:0] idx_r, idx_nxt;
  logic                         phase_r, phase_nxt;   // 0 muons, 1 electrons

  logic in_acc;
  logic op_clear, op_add_mu, op_add_el, op_jet;
  logic mu_has_room, el_has_room;
  logic mu_wr, el_wr;
  logic issue_mu, issue_el;
  logic out_free;
  logic finish;

  // Scan pipe valids
  logic v1_r, c1_r;
  logic v2_r, c2_r;

  assign in_ready = (state_r == jloc_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign op_clear  = in_acc && (jloc_pkg::op_t'(in_opcode) == jloc_pkg::OP_CLEAR);
  assign op_add_mu = in_acc && (jloc_pkg::op_t'(in_opcode) == jloc_pkg::OP_ADD_MU);
  assign op_add_el = in_acc && (jloc_pkg::op_t'(in_opcode) == jloc_pkg::OP_ADD_EL);
  assign op_jet    = in_acc && (jloc_pkg::op_t'(in_opcode) == jloc_pkg::OP_TEST_JET);

  assign mu_has_room = mu_cnt_r < jloc_pkg::LepCntW'(jloc_pkg::MaxLeptons);
  assign el_has_room = el_cnt_r < jloc_pkg::LepCntW'(jloc_pkg::MaxLeptons);
  assign mu_wr       = op_add_mu && mu_has_room;
  assign el_wr       = op_add_el && el_has_room;

  assign out_free = !out_valid || out_ready;
  assign finish   = (state_r == jloc_pkg::ST_FINISH) && out_free;

  // Next state and scan sequencing
  always_comb begin
    state_nxt  = state_r;
    mu_cnt_nxt = mu_cnt_r;
    el_cnt_nxt = el_cnt_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    phase_nxt  = phase_r;
    issue_mu   = 1'b0;
    issue_el   = 1'b0;

    unique case (state_r)
      jloc_pkg::ST_IDLE: begin
        if (op_clear) begin
          mu_cnt_nxt = '0;
          el_cnt_nxt = '0;
          ovf_nxt    = 1'b0;
        end
        if (op_add_mu) begin
          if (mu_has_room) mu_cnt_nxt = mu_cnt_r + 1'b1;
          else             ovf_nxt    = 1'b1;
        end
        if (op_add_el) begin
          if (el_has_room) el_cnt_nxt = el_cnt_r + 1'b1;
          else             ovf_nxt    = 1'b1;
        end
        if (op_jet) begin
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = jloc_pkg::ST_SCAN;
        end
      end
      jloc_pkg::ST_SCAN: begin
        if (!phase_r) begin
          if (idx_r < mu_cnt_r) begin
            issue_mu = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end else begin
            phase_nxt = 1'b1;
            idx_nxt   = '0;
          end
        end else begin
          if (idx_r < el_cnt_r) begin
            issue_el = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end else begin
            state_nxt = jloc_pkg::ST_DRAIN;
          end
        end
      end
      jloc_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = jloc_pkg::ST_FINISH;
      end
      jloc_pkg::ST_FINISH: begin
        if (out_free) state_nxt = jloc_pkg::ST_IDLE;
      end
      default: state_nxt = jloc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= jloc_pkg::ST_IDLE;
      mu_cnt_r <= '0;
      el_cnt_r <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mu_cnt_r <= mu_cnt_nxt;
      el_cnt_r <= el_cnt_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Lepton stores: one write port (add), one registered read (scan)
  // ---------------------------------------------------------------
  jloc_pkg::lep_entry_t mu_mem [jloc_pkg::MaxLeptons];
  jloc_pkg::lep_entry_t el_mem [jloc_pkg::MaxLeptons];
  jloc_pkg::lep_entry_t mu_rd_r;
  jloc_pkg::lep_entry_t el_rd_r;
  jloc_pkg::lep_entry_t new_entry;

  assign new_entry.eta = in_obj_eta;
  assign new_entry.phi = in_obj_phi;

  always_ff @(posedge clk) begin
    if (mu_wr) mu_mem[mu_cnt_r[jloc_pkg::LepIdxW-1:0]] <= new_entry;
    if (issue_mu) mu_rd_r <= mu_mem[idx_r[jloc_pkg::LepIdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (el_wr) el_mem[el_cnt_r[jloc_pkg::LepIdxW-1:0]] <= new_entry;
    if (issue_el) el_rd_r <= el_mem[idx_r[jloc_pkg::LepIdxW-1:0]];
  end

  // ---------------------------------------------------------------
  // Jet capture and acceptance window
  // ---------------------------------------------------------------
  logic signed [jloc_pkg::EtaW-1:0] jet_eta_r;
  logic signed [jloc_pkg::PhiW-1:0] jet_phi_r;
  logic                             acc_r;
  logic [jloc_pkg::EtaW-1:0]        abs_eta;
  logic                             acc_nxt;

  assign abs_eta = in_obj_eta[jloc_pkg::EtaW-1] ? (~in_obj_eta + 1'b1) : in_obj_eta;

  always_comb begin
    acc_nxt = (!cut_en_r[jloc_pkg::CutMinEta] ||
               abs_eta >= jloc_pkg::EtaW'(min_abs_eta_r)) &&
              (!cut_en_r[jloc_pkg::CutMaxEta] ||
               abs_eta <  jloc_pkg::EtaW'(max_abs_eta_r)) &&
              (!cut_en_r[jloc_pkg::CutMinPt] || in_obj_pt >= min_pt_r) &&
              (!cut_en_r[jloc_pkg::CutMaxPt] || in_obj_pt <  max_pt_r);
  end

  always_ff @(posedge clk) begin
    if (op_jet) begin
      jet_eta_r <= in_obj_eta;
      jet_phi_r <= in_obj_phi;
      acc_r     <= acc_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Distance pipe: stage 1 read data, stage 2 squares, stage 3 compare
  // ---------------------------------------------------------------
  jloc_pkg::lep_entry_t               lep;
  logic signed [jloc_pkg::EtaW:0]     deta;
  logic [jloc_pkg::PhiW-1:0]          dphi;
  logic [jloc_pkg::DEtaAbsW-1:0]      deta_abs;
  logic [jloc_pkg::DPhiAbsW-1:0]      dphi_abs;
  logic [jloc_pkg::DEtaSqW-1:0]       deta_sq_r;
  logic [jloc_pkg::DPhiSqW-1:0]       dphi_sq_r;
  logic [jloc_pkg::DistSqW-1:0]       dist_sq;
  logic [jloc_pkg::DistSqW-1:0]       thr;
  logic                               clean_r;

  assign lep  = c1_r ? el_rd_r : mu_rd_r;
  assign deta = {jet_eta_r[jloc_pkg::EtaW-1], jet_eta_r} - {lep.eta[jloc_pkg::EtaW-1], lep.eta};
  // Phi difference wraps modulo a full turn by truncation
  assign dphi = jet_phi_r - lep.phi;
  assign deta_abs = deta[jloc_pkg::EtaW] ? jloc_pkg::DEtaAbsW'(-deta)
                                         : jloc_pkg::DEtaAbsW'(deta);
  assign dphi_abs = dphi[jloc_pkg::PhiW-1] ? (~dphi + 1'b1) : dphi;

  assign dist_sq = jloc_pkg::DistSqW'(deta_sq_r) + jloc_pkg::DistSqW'(dphi_sq_r);
  assign thr     = c2_r ? jloc_pkg::DistSqW'(el_thr_r) : jloc_pkg::DistSqW'(mu_thr_r);

  always_ff @(posedge clk) begin
    deta_sq_r <= deta_abs * deta_abs;
    dphi_sq_r <= dphi_abs * dphi_abs;
    c1_r      <= issue_el;
    c2_r      <= c1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      clean_r <= 1'b1;
    end else begin
      v1_r <= issue_mu || issue_el;
      v2_r <= v1_r;
      if (op_jet) clean_r <= 1'b1;
      else if (v2_r && (dist_sq < thr)) clean_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic out_valid_r;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_jet_pass          <= acc_r && clean_r;
      out_jet_in_acceptance <= acc_r;
      out_jet_clean         <= clean_r;
      out_lepton_overflow   <= ovf_r;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!v1_r && !v2_r))
    else $error("distance pipe busy while taking items");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mu_cnt_r <= jloc_pkg::LepCntW'(jloc_pkg::MaxLeptons)) &&
    (el_cnt_r <= jloc_pkg::LepCntW'(jloc_pkg::MaxLeptons)))
    else $error("lepton count beyond store depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    op_clear |=> (mu_cnt_r == '0 && el_cnt_r == '0 && !ovf_r))
    else $error("clear did not empty the event");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == jloc_pkg::ST_FINISH))
    else $error("result raised outside finish");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_mu || issue_el) |-> (!mu_wr && !el_wr))
    else $error("store written during a scan");

endmodule
